// ----- design/mcs_pkg.sv -----
// Shared types and constants for the matching chain step core.
// Holds field widths, action and mode codes, and the mate store structs.
// No dependencies.
package mcs_pkg;

   localparam int VERTEX_W = 6;
   localparam int EDGE_W = 7;
   localparam int COUNT_W = 32;
   localparam int ACT_W = 3;
   localparam int MODE_W = 2;

   localparam int SIDE_VERTICES_DEF = 64;

   localparam logic [EDGE_W-1:0] EDGE_MAX = 7'd127;
   localparam logic [EDGE_W-1:0] TARGET_RESET = 7'd1;

   localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STEP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TALLY = 2'd2;

   localparam logic [ACT_W-1:0] ACT_HELD = 3'd0;
   localparam logic [ACT_W-1:0] ACT_REMOVED = 3'd1;
   localparam logic [ACT_W-1:0] ACT_ADDED = 3'd2;
   localparam logic [ACT_W-1:0] ACT_SHIFTED = 3'd3;
   localparam logic [ACT_W-1:0] ACT_UNCHANGED = 3'd4;
   localparam logic [ACT_W-1:0] ACT_LOADED = 3'd5;
   localparam logic [ACT_W-1:0] ACT_REJECTED = 3'd6;

   // Update applied to the mate store at the end of a request.
   typedef struct packed {
      logic                link;
      logic [VERTEX_W-1:0] link_left;
      logic [VERTEX_W-1:0] link_right;
      logic                clr_left;
      logic [VERTEX_W-1:0] clr_left_idx;
      logic                clr_right;
      logic [VERTEX_W-1:0] clr_right_idx;
   } mcs_wr_type;

   // Mate lookup for the request's two endpoints.
   typedef struct packed {
      logic                left_valid;
      logic [VERTEX_W-1:0] left_mate;
      logic                right_valid;
      logic [VERTEX_W-1:0] right_mate;
   } mcs_rd_type;

endpackage

// ----- design/mcs_mate_store.sv -----
// Mate tables for both sides of the bipartite graph: synchronous RAMs for
// the mate indices plus flip-flop valid bits cleared by reset.
// Depends on mcs_pkg.
module mcs_mate_store
   import mcs_pkg::*;
#(
   parameter int DEPTH = SIDE_VERTICES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [VERTEX_W-1:0] rd_left,
   input  logic [VERTEX_W-1:0] rd_right,
   input  logic                wr_en,
   input  mcs_wr_type          wr,
   output mcs_rd_type          rd
);

   localparam int IDX_W = $clog2(DEPTH);

   logic [IDX_W-1:0] left_mem [DEPTH];
   logic [IDX_W-1:0] right_mem [DEPTH];

   logic [DEPTH-1:0] left_valid_ff;
   logic [DEPTH-1:0] right_valid_ff;
   logic [DEPTH-1:0] left_valid_in;
   logic [DEPTH-1:0] right_valid_in;
   logic [IDX_W-1:0] left_addr_ff;
   logic [IDX_W-1:0] right_addr_ff;
   logic [IDX_W-1:0] left_data_ff;
   logic [IDX_W-1:0] right_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en && wr.link) begin
         left_mem[wr.link_left[IDX_W-1:0]] <= wr.link_right[IDX_W-1:0];
         right_mem[wr.link_right[IDX_W-1:0]] <= wr.link_left[IDX_W-1:0];
      end
      if (rd_en) begin
         left_data_ff <= left_mem[rd_left[IDX_W-1:0]];
         right_data_ff <= right_mem[rd_right[IDX_W-1:0]];
         left_addr_ff <= rd_left[IDX_W-1:0];
         right_addr_ff <= rd_right[IDX_W-1:0];
      end
   end

   // Clears first so that a new link on the same vertex wins.
   always_comb begin
      left_valid_in = left_valid_ff;
      right_valid_in = right_valid_ff;
      if (wr_en) begin
         if (wr.clr_left) begin
            left_valid_in[wr.clr_left_idx[IDX_W-1:0]] = 1'b0;
         end
         if (wr.clr_right) begin
            right_valid_in[wr.clr_right_idx[IDX_W-1:0]] = 1'b0;
         end
         if (wr.link) begin
            left_valid_in[wr.link_left[IDX_W-1:0]] = 1'b1;
            right_valid_in[wr.link_right[IDX_W-1:0]] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_valid_ff <= '0;
         right_valid_ff <= '0;
      end else begin
         left_valid_ff <= left_valid_in;
         right_valid_ff <= right_valid_in;
      end
   end

   assign rd.left_valid = left_valid_ff[left_addr_ff];
   assign rd.left_mate = VERTEX_W'(left_data_ff);
   assign rd.right_valid = right_valid_ff[right_addr_ff];
   assign rd.right_mate = VERTEX_W'(right_data_ff);

endmodule

// ----- design/matching_chain_step_core.sv -----
// Top level of the matching chain step core: request handling, move decision,
// matching size and saturating tallies. Instantiates mcs_mate_store.
// Depends on mcs_pkg.
//
//   port group | dir | handshake          | payload
//   req_*      | in  | req_valid/ready    | mode, left_vertex, right_vertex, hold_coin
//   rsp_*      | out | rsp_valid/ready    | action, matching_size, full_count, near_count
//   csr_*      | in  | csr_valid/ready    | target_size
//
// A request is handled in ST_IDLE and ST_EXEC: the accept edge issues both
// mate reads, and the commit edge in ST_EXEC commits the result from the
// registered read data. No new request is accepted until the previous one has
// committed. A result waits in the output register while the next request is
// accepted; commit stalls only while that register is full.
// Reset is synchronous and clears all mates, the size and both tallies.
module matching_chain_step_core
   import mcs_pkg::*;
#(
   parameter int SIDE_VERTICES = SIDE_VERTICES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [VERTEX_W-1:0] req_left_vertex,
   input  logic [VERTEX_W-1:0] req_right_vertex,
   input  logic                req_hold_coin,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [ACT_W-1:0]    rsp_action,
   output logic [EDGE_W-1:0]   rsp_matching_size,
   output logic [COUNT_W-1:0]  rsp_full_count,
   output logic [COUNT_W-1:0]  rsp_near_count,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [EDGE_W-1:0]   csr_target_size
);

   localparam int ADDR_SPAN = 2 ** VERTEX_W;
   localparam int DEPTH = (SIDE_VERTICES < ADDR_SPAN) ? SIDE_VERTICES : ADDR_SPAN;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type           state_ff;
   logic [MODE_W-1:0]   mode_ff;
   logic [VERTEX_W-1:0] left_ff;
   logic [VERTEX_W-1:0] right_ff;
   logic                hold_ff;
   logic [EDGE_W-1:0]   target_ff;
   logic [EDGE_W-1:0]   edges_ff;
   logic [COUNT_W-1:0]  full_ff;
   logic [COUNT_W-1:0]  near_ff;
   logic                rsp_valid_ff;
   logic [ACT_W-1:0]    rsp_action_ff;

   logic [EDGE_W-1:0]   edges_in;
   logic [EDGE_W-1:0]   edges_dec;
   logic [COUNT_W-1:0]  full_in;
   logic [COUNT_W-1:0]  near_in;
   logic [ACT_W-1:0]    action_in;
   logic                do_tally;
   logic                in_range;
   logic                accept;
   logic                commit;
   mcs_wr_type          wr;
   mcs_rd_type          rd;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign commit = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;

   mcs_mate_store #(
      .DEPTH(DEPTH)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_left (req_left_vertex),
      .rd_right(req_right_vertex),
      .wr_en   (commit),
      .wr      (wr),
      .rd      (rd)
   );

   assign in_range = (int'(left_ff) < SIDE_VERTICES) && (int'(right_ff) < SIDE_VERTICES);
   assign edges_dec = (edges_ff != '0) ? edges_ff - 1'b1 : edges_ff;

   always_comb begin
      action_in = ACT_UNCHANGED;
      edges_in = edges_ff;
      do_tally = 1'b0;
      wr = '0;
      wr.link_left = left_ff;
      wr.link_right = right_ff;
      unique case (mode_ff)
         MODE_LOAD: begin
            if (in_range && !rd.left_valid && !rd.right_valid && edges_ff < EDGE_MAX) begin
               wr.link = 1'b1;
               edges_in = edges_ff + 1'b1;
               action_in = ACT_LOADED;
            end else begin
               action_in = ACT_REJECTED;
            end
         end
         MODE_STEP: begin
            if (hold_ff) begin
               action_in = ACT_HELD;
            end else begin
               do_tally = 1'b1;
               if (!in_range) begin
                  action_in = ACT_UNCHANGED;
               end else if (rd.left_valid && rd.left_mate == right_ff) begin
                  // drop the chosen edge only from a full matching
                  if (edges_ff == target_ff) begin
                     wr.clr_left = 1'b1;
                     wr.clr_left_idx = left_ff;
                     wr.clr_right = 1'b1;
                     wr.clr_right_idx = rd.left_mate;
                     edges_in = edges_dec;
                     action_in = ACT_REMOVED;
                  end
               end else if ({1'b0, edges_ff} + 1'b1 == {1'b0, target_ff}) begin
                  if (!rd.left_valid && !rd.right_valid) begin
                     wr.link = 1'b1;
                     edges_in = edges_ff + 1'b1;
                     action_in = ACT_ADDED;
                  end else if (rd.left_valid && !rd.right_valid) begin
                     // free the old right mate of the left end, then link
                     wr.clr_right = 1'b1;
                     wr.clr_right_idx = rd.left_mate;
                     wr.link = 1'b1;
                     edges_in = edges_dec + 1'b1;
                     action_in = ACT_SHIFTED;
                  end else if (!rd.left_valid && rd.right_valid) begin
                     wr.clr_left = 1'b1;
                     wr.clr_left_idx = rd.right_mate;
                     wr.link = 1'b1;
                     edges_in = edges_dec + 1'b1;
                     action_in = ACT_SHIFTED;
                  end
               end
            end
         end
         MODE_TALLY: begin
            do_tally = 1'b1;
         end
         default: begin
            action_in = ACT_UNCHANGED;
         end
      endcase
   end

   always_comb begin
      full_in = full_ff;
      near_in = near_ff;
      if (do_tally) begin
         if (edges_in == target_ff) begin
            if (full_ff != '1) begin
               full_in = full_ff + 1'b1;
            end
         end else if (near_ff != '1) begin
            near_in = near_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         target_ff <= TARGET_RESET;
         edges_ff <= '0;
         full_ff <= '0;
         near_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            target_ff <= csr_target_size;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_EXEC;
               end
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_EXEC: begin
               if (commit) begin
                  edges_ff <= edges_in;
                  full_ff <= full_in;
                  near_ff <= near_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         left_ff <= req_left_vertex;
         right_ff <= req_right_vertex;
         hold_ff <= req_hold_coin;
      end
      if (commit) begin
         rsp_action_ff <= action_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_action = rsp_action_ff;
   assign rsp_matching_size = edges_ff;
   assign rsp_full_count = full_ff;
   assign rsp_near_count = near_ff;

endmodule
